>>> rtl/core/perm_enum_pkg.sv
// ----------------------------------------------------------------------------
// perm_enum_pkg
// Widths, sizes and request codes of the permutation enumerator.
// ----------------------------------------------------------------------------
package perm_enum_pkg;

   localparam int MAX_ENTRIES = 8;
   localparam int IDX_W       = 3;
   localparam int VALUE_W     = 16;
   localparam int SIZE_W      = 4;
   localparam int OPCODE_W    = 2;

   localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_NEXT    = 2'd2;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [SIZE_W-1:0]  size_type;

endpackage

>>> rtl/core/permutation_enumerator.sv
// ----------------------------------------------------------------------------
// permutation_enumerator
// Steps through every ordering of the first set_size table entries in
// lexicographic order of table positions, one ordering per next request.
//
//   channel | direction | ports                                   | beat
//   req     | in        | opcode, entry_index, entry_value        | valid & !stall
//   rsp     | out       | element_value, last_element, exhausted  | valid & !stall
//   csr     | in        | write_enable, write_data (set_size)     | write_enable
//
// A load writes the value table and leaves the sequencer idle. A restart
// seeds the path memory, then emits each element by a path read, a table
// read and an output step. A next request scans the path memory once for
// the pivot and once for its successor, swaps the two, reverses the tail
// pair by pair, then emits; all of it is bound by the single path port.
// Reset is synchronous and leaves the block idle with nothing started.
// A stalled result holds the sequencer; a new request is taken once idle.
// ----------------------------------------------------------------------------
module permutation_enumerator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [perm_enum_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [perm_enum_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [perm_enum_pkg::VALUE_W-1:0]   req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [perm_enum_pkg::VALUE_W-1:0]   rsp_element_value,
   output logic                                rsp_last_element,
   output logic                                rsp_exhausted,
   input  logic                                csr_write_enable,
   input  logic [perm_enum_pkg::SIZE_W-1:0]    csr_write_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_FINDJ = 4'd3;
   localparam logic [3:0] S_SWAP  = 4'd4;
   localparam logic [3:0] S_REV   = 4'd5;
   localparam logic [3:0] S_REV_B = 4'd6;
   localparam logic [3:0] S_REV_C = 4'd7;
   localparam logic [3:0] S_REV_D = 4'd8;
   localparam logic [3:0] S_PATH  = 4'd9;
   localparam logic [3:0] S_TAB   = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;
   localparam logic [3:0] S_EXH   = 4'd12;

   localparam int DEPTH = perm_enum_pkg::MAX_ENTRIES;

   logic [3:0]                   state_ff, state_in;
   logic                         done_ff, done_in;
   perm_enum_pkg::size_type      size_ff, size_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   perm_enum_pkg::value_type     rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_exh_ff, rsp_exh_in;

   perm_enum_pkg::idx_type       idx_ff, idx_in;
   perm_enum_pkg::idx_type       j_ff, j_in;
   perm_enum_pkg::idx_type       piv_ff, piv_in;
   perm_enum_pkg::idx_type       pv_ff, pv_in;
   perm_enum_pkg::idx_type       prev_ff, prev_in;
   perm_enum_pkg::idx_type       lo_ff, lo_in;
   perm_enum_pkg::idx_type       hi_ff, hi_in;
   perm_enum_pkg::idx_type       a_ff, a_in;
   perm_enum_pkg::idx_type       k_ff, k_in;
   logic                         first_ff, first_in;

   perm_enum_pkg::idx_type       path_mem [DEPTH];
   perm_enum_pkg::idx_type       path_rdata_ff;
   logic                         path_re, path_we;
   perm_enum_pkg::idx_type       path_addr, path_wdata;

   perm_enum_pkg::value_type     tab_mem [DEPTH];
   perm_enum_pkg::value_type     tab_rdata_ff;

   perm_enum_pkg::size_type      n_eff;
   perm_enum_pkg::size_type      nm1_full;
   perm_enum_pkg::idx_type       nm1;
   logic                         req_beat, rsp_free, load_beat, found;

   always_comb begin
      if (size_ff == '0) begin
         n_eff = perm_enum_pkg::SIZE_W'(1);
      end else if (size_ff > perm_enum_pkg::SIZE_W'(perm_enum_pkg::MAX_ENTRIES)) begin
         n_eff = perm_enum_pkg::SIZE_W'(perm_enum_pkg::MAX_ENTRIES);
      end else begin
         n_eff = size_ff;
      end
   end

   assign nm1_full  = n_eff - perm_enum_pkg::SIZE_W'(1);
   assign nm1       = nm1_full[perm_enum_pkg::IDX_W-1:0];
   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign load_beat = req_beat && (req_opcode == perm_enum_pkg::OP_LOAD);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign found     = !first_ff && (path_rdata_ff < prev_ff);

   // sequencer and path memory port
   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      size_in      = size_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_exh_in   = rsp_exh_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      piv_in       = piv_ff;
      pv_in        = pv_ff;
      prev_in      = prev_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      k_in         = k_ff;
      first_in     = first_ff;
      path_re      = 1'b0;
      path_we      = 1'b0;
      path_addr    = '0;
      path_wdata   = '0;

      if (csr_write_enable) begin
         size_in = csr_write_data;
         done_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               priority if (req_opcode == perm_enum_pkg::OP_RESTART) begin
                  done_in  = 1'b0;
                  k_in     = '0;
                  state_in = S_INIT;
               end else if (req_opcode == perm_enum_pkg::OP_NEXT) begin
                  if (done_ff || (n_eff < perm_enum_pkg::SIZE_W'(2))) begin
                     done_in  = 1'b1;
                     state_in = S_EXH;
                  end else begin
                     path_re   = 1'b1;
                     path_addr = nm1;
                     idx_in    = nm1;
                     first_in  = 1'b1;
                     state_in  = S_SCAN;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_INIT: begin
            path_we    = 1'b1;
            path_addr  = k_ff;
            path_wdata = k_ff;
            if (k_ff == nm1) begin
               k_in     = '0;
               state_in = S_PATH;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (found) begin
               piv_in    = idx_ff;
               pv_in     = path_rdata_ff;
               path_re   = 1'b1;
               path_addr = nm1;
               j_in      = nm1;
               state_in  = S_FINDJ;
            end else if (idx_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_EXH;
            end else begin
               prev_in   = path_rdata_ff;
               first_in  = 1'b0;
               path_re   = 1'b1;
               path_addr = idx_ff - 1'b1;
               idx_in    = idx_ff - 1'b1;
            end
         end
         S_FINDJ: begin
            if (path_rdata_ff > pv_ff) begin
               path_we    = 1'b1;
               path_addr  = piv_ff;
               path_wdata = path_rdata_ff;
               state_in   = S_SWAP;
            end else begin
               path_re   = 1'b1;
               path_addr = j_ff - 1'b1;
               j_in      = j_ff - 1'b1;
            end
         end
         S_SWAP: begin
            path_we    = 1'b1;
            path_addr  = j_ff;
            path_wdata = pv_ff;
            lo_in      = piv_ff + 1'b1;
            hi_in      = nm1;
            state_in   = S_REV;
         end
         S_REV: begin
            if (lo_ff < hi_ff) begin
               path_re   = 1'b1;
               path_addr = lo_ff;
               state_in  = S_REV_B;
            end else begin
               k_in     = '0;
               state_in = S_PATH;
            end
         end
         S_REV_B: begin
            a_in      = path_rdata_ff;
            path_re   = 1'b1;
            path_addr = hi_ff;
            state_in  = S_REV_C;
         end
         S_REV_C: begin
            path_we    = 1'b1;
            path_addr  = lo_ff;
            path_wdata = path_rdata_ff;
            state_in   = S_REV_D;
         end
         S_REV_D: begin
            path_we    = 1'b1;
            path_addr  = hi_ff;
            path_wdata = a_ff;
            lo_in      = lo_ff + 1'b1;
            hi_in      = hi_ff - 1'b1;
            state_in   = S_REV;
         end
         S_PATH: begin
            path_re   = 1'b1;
            path_addr = k_ff;
            state_in  = S_TAB;
         end
         S_TAB: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = tab_rdata_ff;
               rsp_last_in  = (k_ff == nm1);
               rsp_exh_in   = 1'b0;
               if (k_ff == nm1) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_PATH;
               end
            end
         end
         S_EXH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               rsp_exh_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b1;
         size_ff      <= perm_enum_pkg::SIZE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_exh_ff   <= rsp_exh_in;
      idx_ff       <= idx_in;
      j_ff         <= j_in;
      piv_ff       <= piv_in;
      pv_ff        <= pv_in;
      prev_ff      <= prev_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      a_ff         <= a_in;
      k_ff         <= k_in;
      first_ff     <= first_in;
   end

   // path memory, single port
   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_addr] <= path_wdata;
      end
      if (path_re) begin
         path_rdata_ff <= path_mem[path_addr];
      end
   end

   // value table, written by loads, read at the stored position
   always_ff @(posedge clock) begin
      if (load_beat) begin
         tab_mem[req_entry_index] <= req_entry_value;
      end
      if (state_ff == S_TAB) begin
         tab_rdata_ff <= tab_mem[path_rdata_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_last_element  = rsp_last_ff;
   assign rsp_exhausted     = rsp_exh_ff;

   a_exh_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_exhausted) |-> (rsp_last_element && (rsp_element_value == '0)))
      else $error("exhausted beat not marked last or not zero");

   a_port_single: assert property (@(posedge clock) disable iff (reset)
      !(path_we && path_re))
      else $error("path memory read and write in one cycle");

   a_succ_above_pivot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINDJ) |-> (j_ff > piv_ff))
      else $error("successor search passed the pivot");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && rsp_valid && rsp_stall) |=> (state_ff == S_OUT))
      else $error("element dropped while result stalled");

endmodule

>>> verif/permutation_enumerator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_enumerator_test
// Self-checking bench for the permutation enumerator. A directed table loads
// the value table and walks the size and request corner cases, and then
// random phases follow. Each phase writes a new set size, restarts and steps
// through orderings, with loads and unused codes mixed in. Every result beat
// is checked against a shadow enumerator kept in the bench, or against the
// result that a directed row names. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module permutation_enumerator_test;

   localparam logic [perm_enum_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 64;
   localparam int RANDOM_ITEMS  = 100;
   localparam int DIRECTED_ROWS = 27;

   typedef struct packed {
      perm_enum_pkg::value_type value;
      logic                     last;
      logic                     exhausted;
   } element_beat_type;

   typedef struct packed {
      logic                               to_csr;
      logic [perm_enum_pkg::OPCODE_W-1:0] opcode;
      perm_enum_pkg::idx_type             index;
      perm_enum_pkg::value_type           value;
      logic                               typed;
      perm_enum_pkg::value_type           want_value;
      logic                               want_exhausted;
   } stim_row_type;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b1, 16'h0000, 1'b1},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd1, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd2, 16'h5555, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd3, 16'hAAAA, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd4, 16'h1234, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd5, 16'h8001, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd6, 16'h7FFE, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd7, 16'h00FF, 1'b0, 16'h0000, 1'b0},
      '{1'b0, OP_UNUSED,                 3'd5, 16'hDEAD, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_RESTART, 3'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
      '{1'b1, perm_enum_pkg::OP_LOAD,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b1, 16'h0000, 1'b1},
      '{1'b0, perm_enum_pkg::OP_RESTART, 3'd0, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
      '{1'b1, perm_enum_pkg::OP_LOAD,    3'd0, 16'h0003, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_RESTART, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b1, 16'h0000, 1'b1},
      '{1'b1, perm_enum_pkg::OP_LOAD,    3'd0, 16'h000F, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_RESTART, 3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_LOAD,    3'd7, 16'h4242, 1'b0, 16'h0000, 1'b0},
      '{1'b0, perm_enum_pkg::OP_NEXT,    3'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}
   };

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic                               req_stall;
   logic [perm_enum_pkg::OPCODE_W-1:0] req_opcode       = perm_enum_pkg::OP_LOAD;
   perm_enum_pkg::idx_type             req_entry_index  = '0;
   perm_enum_pkg::value_type           req_entry_value  = '0;
   logic                               rsp_valid;
   logic                               rsp_stall        = 1'b0;
   perm_enum_pkg::value_type           rsp_element_value;
   logic                               rsp_last_element;
   logic                               rsp_exhausted;
   logic                               csr_write_enable = 1'b0;
   perm_enum_pkg::size_type            csr_write_data   = '0;

   permutation_enumerator uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_value (rsp_element_value),
      .rsp_last_element  (rsp_last_element),
      .rsp_exhausted     (rsp_exhausted),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // shadow enumerator
   perm_enum_pkg::value_type shadow_table [perm_enum_pkg::MAX_ENTRIES];
   perm_enum_pkg::idx_type   shadow_path  [perm_enum_pkg::MAX_ENTRIES];
   logic                     shadow_done;
   perm_enum_pkg::size_type  shadow_size;
   element_beat_type         expected_beats [$];

   int  fail_count     = 0;
   int  beat_count     = 0;
   int  orderings_seen = 0;
   int  exhausted_seen = 0;
   int  size_writes    = 0;
   int  cycle_count    = 0;
   int  hold_count     = 0;
   bit  quiet          = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  expected_beats.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int active_size();
      if (shadow_size == 0) return 1;
      if (shadow_size > perm_enum_pkg::MAX_ENTRIES) return perm_enum_pkg::MAX_ENTRIES;
      return int'(shadow_size);
   endfunction

   // next lexicographic ordering of positions; 0 when the last one is reached
   function automatic bit advance_positions(int n);
      int                     i;
      int                     j;
      int                     lo;
      int                     hi;
      perm_enum_pkg::idx_type t;
      if (n < 2) return 1'b0;
      i = n - 1;
      while (i > 0 && shadow_path[i-1] >= shadow_path[i]) i--;
      if (i == 0) return 1'b0;
      i--;
      j = n - 1;
      while (shadow_path[j] <= shadow_path[i]) j--;
      t = shadow_path[i];
      shadow_path[i] = shadow_path[j];
      shadow_path[j] = t;
      lo = i + 1;
      hi = n - 1;
      while (lo < hi) begin
         t = shadow_path[lo];
         shadow_path[lo] = shadow_path[hi];
         shadow_path[hi] = t;
         lo++;
         hi--;
      end
      return 1'b1;
   endfunction

   task automatic predict_orderings(input logic [perm_enum_pkg::OPCODE_W-1:0] op,
                                    input perm_enum_pkg::idx_type idx,
                                    input perm_enum_pkg::value_type val,
                                    output element_beat_type beats [perm_enum_pkg::MAX_ENTRIES],
                                    output int count);
      int n;
      int k;
      bit emit;
      n = active_size();
      count = 0;
      emit = 1'b0;
      case (op)
         perm_enum_pkg::OP_LOAD: begin
            shadow_table[idx] = val;
         end
         perm_enum_pkg::OP_RESTART: begin
            for (k = 0; k < perm_enum_pkg::MAX_ENTRIES; k++)
               shadow_path[k] = (k < n) ? perm_enum_pkg::idx_type'(k) : '0;
            shadow_done = 1'b0;
            emit = 1'b1;
         end
         perm_enum_pkg::OP_NEXT: begin
            if (shadow_done) begin
               beats[0] = '{16'h0000, 1'b1, 1'b1};
               count = 1;
            end else if (!advance_positions(n)) begin
               shadow_done = 1'b1;
               beats[0] = '{16'h0000, 1'b1, 1'b1};
               count = 1;
            end else begin
               emit = 1'b1;
            end
         end
         default: ;
      endcase
      if (emit) begin
         for (k = 0; k < n; k++) beats[k] = '{shadow_table[shadow_path[k]], k == n - 1, 1'b0};
         count = n;
      end
   endtask

   task automatic send_request(input logic [perm_enum_pkg::OPCODE_W-1:0] op,
                               input perm_enum_pkg::idx_type idx,
                               input perm_enum_pkg::value_type val, input logic typed,
                               input perm_enum_pkg::value_type want_value,
                               input logic want_exhausted);
      element_beat_type beats [perm_enum_pkg::MAX_ENTRIES];
      int               count;
      int               gap;
      int               k;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_entry_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_orderings(op, idx, val, beats, count);
      if (typed) begin
         expected_beats.push_back(element_beat_type'{want_value, 1'b1, want_exhausted});
      end else begin
         for (k = 0; k < count; k++) expected_beats.push_back(beats[k]);
      end
   endtask

   // only while idle: every beat back and the last load long retired
   task automatic write_set_size(input perm_enum_pkg::size_type size);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_size = size;
      shadow_done = 1'b1;
      size_writes++;
   endtask

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("mismatch: %s", what);
   endtask

   always @(posedge clock) begin
      if (hold_count > 0) begin
         hold_count--;
      end else if (quiet || rsp_stall) begin
         rsp_stall  <= 1'b0;
         hold_count = $urandom_range(0, 12);
      end else begin
         rsp_stall  <= 1'b1;
         hold_count = pick_gap();
      end
   end

   always @(posedge clock) begin : result_check
      element_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beat_count++;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_element_value !== want.value)
               report_mismatch($sformatf("beat %0d element_value %h, wanted %h",
                                         beat_count, rsp_element_value, want.value));
            if (rsp_last_element !== want.last)
               report_mismatch($sformatf("beat %0d last_element %b, wanted %b",
                                         beat_count, rsp_last_element, want.last));
            if (rsp_exhausted !== want.exhausted)
               report_mismatch($sformatf("beat %0d exhausted %b, wanted %b",
                                         beat_count, rsp_exhausted, want.exhausted));
            if (want.exhausted) exhausted_seen++;
            else if (want.last) orderings_seen++;
         end
      end
   end

   initial begin
      int                      row;
      int                      r;
      int                      n;
      int                      k;
      int                      steps;
      int                      random_items;
      perm_enum_pkg::size_type size;
      for (k = 0; k < perm_enum_pkg::MAX_ENTRIES; k++) begin
         shadow_table[k] = '0;
         shadow_path[k]  = '0;
      end
      shadow_done  = 1'b1;
      shadow_size  = perm_enum_pkg::size_type'(1);
      random_items = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].to_csr)
            write_set_size(perm_enum_pkg::size_type'(DIRECTED[row].value));
         else
            send_request(DIRECTED[row].opcode, DIRECTED[row].index, DIRECTED[row].value,
                         DIRECTED[row].typed, DIRECTED[row].want_value,
                         DIRECTED[row].want_exhausted);
      end

      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r < 12)      size = perm_enum_pkg::size_type'($urandom_range(1, 3));
         else if (r < 16) size = perm_enum_pkg::size_type'($urandom_range(4, 6));
         else if (r < 18) size = perm_enum_pkg::size_type'($urandom_range(7, 8));
         else if (r < 19) size = '0;
         else             size = perm_enum_pkg::size_type'($urandom_range(9, 15));
         quiet = 1'b0;
         write_set_size(size);
         quiet = ($urandom_range(0, 3) == 0);
         n = active_size();
         if (n <= 3) steps = ((n == 1) ? 1 : (n == 2) ? 2 : 6) + $urandom_range(0, 1);
         else        steps = $urandom_range(3, 8);

         // a next straight after the size write must see nothing running
         if ($urandom_range(0, 7) == 0) begin
            send_request(perm_enum_pkg::OP_NEXT, perm_enum_pkg::idx_type'($urandom),
                         perm_enum_pkg::value_type'($urandom), 1'b0, '0, 1'b0);
            random_items++;
         end
         send_request(perm_enum_pkg::OP_RESTART, perm_enum_pkg::idx_type'($urandom),
                      perm_enum_pkg::value_type'($urandom), 1'b0, '0, 1'b0);
         random_items++;
         for (k = 0; k < steps; k++) begin
            r = $urandom_range(0, 19);
            if (r < 2) begin
               send_request(perm_enum_pkg::OP_LOAD, perm_enum_pkg::idx_type'($urandom),
                            perm_enum_pkg::value_type'($urandom), 1'b0, '0, 1'b0);
               random_items++;
            end else if (r < 3) begin
               send_request(OP_UNUSED, perm_enum_pkg::idx_type'($urandom),
                            perm_enum_pkg::value_type'($urandom), 1'b0, '0, 1'b0);
            end else if (r < 4) begin
               send_request(perm_enum_pkg::OP_RESTART, perm_enum_pkg::idx_type'($urandom),
                            perm_enum_pkg::value_type'($urandom), 1'b0, '0, 1'b0);
               random_items++;
            end else begin
               send_request(perm_enum_pkg::OP_NEXT, perm_enum_pkg::idx_type'($urandom),
                            perm_enum_pkg::value_type'($urandom), 1'b0, '0, 1'b0);
               random_items++;
            end
         end
      end

      req_valid <= 1'b0;
      quiet = 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d result beats checked: %0d orderings and %0d exhausted answers",
               beat_count, orderings_seen, exhausted_seen);
      $display("%0d set size writes, %0d random requests after the directed table",
               size_writes, random_items);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
